// ===== hw/rtl/window_median_filter_defines.svh =====
// Assertion macros for the checker file of the median filter.
`ifndef WINDOW_MEDIAN_FILTER_DEFINES_SVH
`define WINDOW_MEDIAN_FILTER_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define WMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define WMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define WMF_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/wmf_pkg.sv =====
`default_nettype none
package wmf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIXEL_BITS = 8;

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
  localparam int SIZE_BITS = 11;
  localparam int CFG_BITS  = 11;
  localparam int IDX_BITS  = 2;

  localparam int WIN      = 5;
  localparam int WIN_N    = WIN * WIN;
  localparam int BANKS    = 4;
  localparam int SLOT_BITS = 2;
  localparam int RANK_BITS = 5;

  localparam logic [RANK_BITS-1:0] MED3_RANK = RANK_BITS'(4);
  localparam logic [RANK_BITS-1:0] MED5_RANK = RANK_BITS'(12);

  localparam logic [IDX_BITS-1:0] REG_WINDOW_MODE  = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd2;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef pixel_t [WIN_N-1:0] win_vals_t;

  // State handed from one rank cell to the next.
  typedef struct packed {
    logic                  valid;
    win_vals_t             vals;
    logic [WIN_N-1:0]      active;
    logic [RANK_BITS-1:0]  rank;
    pixel_t                med;
    logic [ROW_BITS-1:0]   row;
    logic [COL_BITS-1:0]   col;
    logic                  last;
  } rank_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wmf_line_bank.sv =====
`default_nettype none
module wmf_line_bank
  import wmf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rd_en,
  input  wire logic                wr_en,
  input  wire logic [COL_BITS-1:0] addr,
  input  wire pixel_t              wdata,
  output pixel_t                   rdata
);

  pixel_t mem [MAX_WIDTH];

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/wmf_window.sv =====
`default_nettype none
module wmf_window
  import wmf_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          shift,
  input  wire pixel_t [WIN-1:0] col_in,
  output win_vals_t          vals
);

  pixel_t win [WIN][WIN];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (shift) begin
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN - 1; j++) begin
          win[i][j] <= win[i][j+1];
        end
        win[i][WIN-1] <= col_in[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN; j++) begin
        vals[i*WIN+j] = win[i][j];
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/wmf_rank_cell.sv =====
`default_nettype none
module wmf_rank_cell
  import wmf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire rank_state_t d,
  output rank_state_t q
);

  // Decides one answer bit from the top bit of every value, then shifts
  // the values left so the next cell sees the following bit.
  rank_state_t          nxt;
  logic [RANK_BITS-1:0] zeros;
  logic                 bit_one;

  always_comb begin
    zeros = '0;
    for (int i = 0; i < WIN_N; i++) begin
      zeros = zeros + RANK_BITS'(d.active[i] & ~d.vals[i][PIXEL_BITS-1]);
    end
    bit_one = (d.rank >= zeros);
    nxt = d;
    nxt.med = {d.med[PIXEL_BITS-2:0], bit_one};
    if (bit_one) begin
      nxt.rank = d.rank - zeros;
    end
    for (int i = 0; i < WIN_N; i++) begin
      nxt.active[i] = d.active[i] & (d.vals[i][PIXEL_BITS-1] == bit_one);
      nxt.vals[i]   = {d.vals[i][PIXEL_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= nxt.valid;
    end
    if (en) begin
      q.vals   <= nxt.vals;
      q.active <= nxt.active;
      q.rank   <= nxt.rank;
      q.med    <= nxt.med;
      q.row    <= nxt.row;
      q.col    <= nxt.col;
      q.last   <= nxt.last;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/window_median_filter.sv =====
// Streaming 3x3 / 5x5 median filter, one pixel transfer per clock unless stalled.
// A result passes stage one, the window with stage two, then the rank cells.
// Throughput: one pixel per cycle; the line store, the window and the eight
// rank cells all advance together whenever the output register can move.
// Reset (synchronous, active high) clears counters, window and valid bits; the
// line store contents are undefined until written.
`default_nettype none
module window_median_filter
  import wmf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_BITS-1:0]  cfg_data,
  input  wire logic                 pixel_valid,
  output logic                      pixel_ready,
  input  wire pixel_t               pixel_value,
  output logic                      median_valid,
  input  wire logic                 median_ready,
  output pixel_t                    median_value,
  output logic [ROW_BITS-1:0]       center_row,
  output logic [COL_BITS-1:0]       center_col,
  output logic                      frame_last
);

  localparam int CELLS = PIXEL_BITS;

  // Configuration. Frame sizes are saturated into range when written.
  logic                 window_mode;
  logic [SIZE_BITS-1:0] frame_width;
  logic [SIZE_BITS-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_mode  <= 1'b0;
      frame_width  <= SIZE_BITS'(512);
      frame_height <= SIZE_BITS'(512);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WINDOW_MODE: window_mode <= cfg_data[0];
        REG_FRAME_WIDTH: begin
          if (cfg_data < CFG_BITS'(5)) begin
            frame_width <= SIZE_BITS'(5);
          end else if (cfg_data > CFG_BITS'(MAX_WIDTH)) begin
            frame_width <= SIZE_BITS'(MAX_WIDTH);
          end else begin
            frame_width <= cfg_data;
          end
        end
        REG_FRAME_HEIGHT: begin
          if (cfg_data < CFG_BITS'(5)) begin
            frame_height <= SIZE_BITS'(5);
          end else if (cfg_data > CFG_BITS'(MAX_HEIGHT)) begin
            frame_height <= SIZE_BITS'(MAX_HEIGHT);
          end else begin
            frame_height <= cfg_data;
          end
        end
        default: ;
      endcase
    end
  end

  // The whole pipeline moves as one whenever the output register is free or
  // being drained, so a result that is being taken does not block the next transfer.
  rank_state_t cell_q [CELLS];
  logic        en;
  logic        in_fire;

  assign en          = !cell_q[CELLS-1].valid || median_ready;
  assign pixel_ready = en;
  assign in_fire     = pixel_valid && en;

  // Raster position of the next pixel.
  logic [COL_BITS-1:0] col_count, col_count_next;
  logic [ROW_BITS-1:0] row_count, row_count_next;
  logic                emit_now;
  logic                last_now;
  logic [ROW_BITS-1:0] row_ctr;
  logic [COL_BITS-1:0] col_ctr;

  always_comb begin
    logic [SIZE_BITS-1:0] c_ext;
    logic [SIZE_BITS-1:0] r_ext;
    logic [SIZE_BITS-1:0] span;
    c_ext = SIZE_BITS'(col_count);
    r_ext = SIZE_BITS'(row_count);
    span  = window_mode ? SIZE_BITS'(4) : SIZE_BITS'(2);
    emit_now = (c_ext < frame_width) && (r_ext < frame_height) &&
               (c_ext >= span) && (r_ext >= span);
    last_now = (c_ext == frame_width - 1'b1) && (r_ext == frame_height - 1'b1);
    row_ctr  = row_count - (window_mode ? ROW_BITS'(2) : ROW_BITS'(1));
    col_ctr  = col_count - (window_mode ? COL_BITS'(2) : COL_BITS'(1));
    if (c_ext + 1'b1 >= frame_width) begin
      col_count_next = '0;
      row_count_next = (r_ext + 1'b1 >= frame_height) ? '0 : row_count + 1'b1;
    end else begin
      col_count_next = col_count + 1'b1;
      row_count_next = (r_ext >= frame_height) ? '0 : row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_fire) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // Four line banks; the bank of slot row mod 4 takes the new pixel while
  // every bank returns the pixel of its older row in the same column.
  pixel_t bank_rd [BANKS];

  for (genvar s = 0; s < BANKS; s++) begin : g_bank
    wmf_line_bank u_bank (
      .clk   (clk),
      .rd_en (in_fire),
      .wr_en (in_fire && (row_count[SLOT_BITS-1:0] == SLOT_BITS'(s))),
      .addr  (col_count),
      .wdata (pixel_value),
      .rdata (bank_rd[s])
    );
  end

  // Stage one: bank read data plus the position of the transfer.
  logic                 s1_valid;
  logic                 s1_emit;
  logic                 s1_mode;
  logic                 s1_last;
  logic [SLOT_BITS-1:0] s1_slot;
  pixel_t               s1_pix;
  logic [ROW_BITS-1:0]  s1_row;
  logic [COL_BITS-1:0]  s1_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pixel_valid;
    end
    if (in_fire) begin
      s1_emit <= emit_now;
      s1_mode <= window_mode;
      s1_last <= last_now;
      s1_slot <= row_count[SLOT_BITS-1:0];
      s1_pix  <= pixel_value;
      s1_row  <= row_ctr;
      s1_col  <= col_ctr;
    end
  end

  // Window row i takes the bank holding row (r - 4 + i).
  pixel_t [WIN-1:0] new_col;

  always_comb begin
    for (int i = 0; i < BANKS; i++) begin
      new_col[i] = bank_rd[SLOT_BITS'(s1_slot + SLOT_BITS'(i))];
    end
    new_col[WIN-1] = s1_pix;
  end

  win_vals_t win_vals;

  wmf_window u_window (
    .clk    (clk),
    .rst    (rst),
    .shift  (en && s1_valid),
    .col_in (new_col),
    .vals   (win_vals)
  );

  // Stage two: the updated window with the result position.
  logic                s2_valid;
  logic                s2_mode;
  logic                s2_last;
  logic [ROW_BITS-1:0] s2_row;
  logic [COL_BITS-1:0] s2_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid && s1_emit;
    end
    if (en) begin
      s2_mode <= s1_mode;
      s2_last <= s1_last;
      s2_row  <= s1_row;
      s2_col  <= s1_col;
    end
  end

  // The 3x3 window is the lower right corner of the 5x5 window.
  rank_state_t seed;

  always_comb begin
    seed.valid = s2_valid;
    seed.vals  = win_vals;
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN; j++) begin
        seed.active[i*WIN+j] = s2_mode || ((i >= 2) && (j >= 2));
      end
    end
    seed.rank = s2_mode ? MED5_RANK : MED3_RANK;
    seed.med  = '0;
    seed.row  = s2_row;
    seed.col  = s2_col;
    seed.last = s2_last;
  end

  // Chain of rank cells: each settles one bit of the median, top bit first.
  for (genvar n = 0; n < CELLS; n++) begin : g_cell
    wmf_rank_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   ((n == 0) ? seed : cell_q[(n == 0) ? 0 : n-1]),
      .q   (cell_q[n])
    );
  end

  assign median_valid = cell_q[CELLS-1].valid;
  assign median_value = cell_q[CELLS-1].med;
  assign center_row   = cell_q[CELLS-1].row;
  assign center_col   = cell_q[CELLS-1].col;
  assign frame_last   = cell_q[CELLS-1].last;

endmodule
`default_nettype wire

// ===== hw/rtl/wmf_checker.sv =====
`default_nettype none
`include "window_median_filter_defines.svh"
module wmf_checker
  import wmf_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                pixel_ready,
  input wire logic                median_valid,
  input wire logic                median_ready,
  input wire pixel_t              median_value,
  input wire logic [ROW_BITS-1:0] center_row,
  input wire logic [COL_BITS-1:0] center_col
);

  `WMF_ASSERT_NEXT(a_hold, median_valid && !median_ready, median_valid && $stable(median_value) && $stable(center_row) && $stable(center_col), "result changed while stalled")
  `WMF_ASSERT_NOW(a_ready, !median_valid, pixel_ready, "input blocked with empty output")
  `WMF_ASSERT_NOW(a_interior, median_valid, (center_row != '0) && (center_col != '0), "border centre reported")
  `WMF_ASSERT_ALWAYS(a_reset, rst, !median_valid, "result right after reset")

endmodule

bind window_median_filter wmf_checker u_wmf_checker (.*);
`default_nettype wire

// ===== tb/window_median_filter_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
// Watches the pixel, configuration and median channels, keeps its own copy of the
// filter state and compares every median transfer with the oldest prediction.
module window_median_filter_checker
  import wmf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0] cfg_data,
  input  wire logic                pixel_valid,
  input  wire logic                pixel_ready,
  input  wire pixel_t              pixel_value,
  input  wire logic                median_valid,
  input  wire logic                median_ready,
  input  wire pixel_t              median_value,
  input  wire logic [ROW_BITS-1:0] center_row,
  input  wire logic [COL_BITS-1:0] center_col,
  input  wire logic                frame_last,
  output int                       fail_count,
  output int                       pending,
  output int                       result_count
);

  typedef struct packed {
    pixel_t              med;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                last;
  } median_rec_t;

  median_rec_t expected_medians[$];

  pixel_t      rows_mem [BANKS*MAX_WIDTH];
  pixel_t      win [WIN][WIN];
  int unsigned col_pos, row_pos;
  logic        mode_5x5;
  logic [CFG_BITS-1:0] width_reg, height_reg;

  assign pending = expected_medians.size();

  function automatic int unsigned clamp_dim(logic [CFG_BITS-1:0] v, int unsigned hi);
    if (v < 5) return 5;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the model by one pixel; queues a median when the window is interior.
  task automatic take_pixel(pixel_t pix);
    int unsigned w, h, c, r, k, lo, n;
    pixel_t vals[25];
    pixel_t key;
    int i, j;
    median_rec_t rec;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    c = col_pos;
    r = row_pos;
    k = mode_5x5 ? 2 : 1;
    if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
    for (i = 0; i < 5; i++)
      for (j = 0; j < 4; j++)
        win[i][j] = win[i][j+1];
    for (i = 0; i < 4; i++)
      win[i][4] = rows_mem[((r + i) % 4) * MAX_WIDTH + c];
    win[4][4] = pix;
    rows_mem[(r % 4) * MAX_WIDTH + c] = pix;
    if (c < w && r < h && c >= 2*k && r >= 2*k) begin
      lo = 4 - 2*k;
      n = 0;
      for (i = lo; i < 5; i++)
        for (j = lo; j < 5; j++) begin
          vals[n] = win[i][j];
          n++;
        end
      // Insertion sort of the active window, then pick the middle rank.
      for (i = 1; i < n; i++) begin
        key = vals[i];
        j = i - 1;
        while (j >= 0 && vals[j] > key) begin
          vals[j+1] = vals[j];
          j--;
        end
        vals[j+1] = key;
      end
      rec.med  = vals[(k == 2) ? MED5_RANK : MED3_RANK];
      rec.row  = ROW_BITS'(r - k);
      rec.col  = COL_BITS'(c - k);
      rec.last = (c == w - 1 && r == h - 1);
      expected_medians.push_back(rec);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = (r >= h) ? 0 : r;
    end
  endtask

  task automatic check_median();
    median_rec_t want;
    if (expected_medians.size() == 0) begin
      $error("median transfer with nothing expected: value %0d row %0d col %0d",
             median_value, center_row, center_col);
      fail_count++;
      return;
    end
    want = expected_medians.pop_front();
    if (median_value !== want.med) begin
      $error("median_value: expected %0d, actual %0d", want.med, median_value);
      fail_count++;
    end
    if (center_row !== want.row) begin
      $error("center_row: expected %0d, actual %0d", want.row, center_row);
      fail_count++;
    end
    if (center_col !== want.col) begin
      $error("center_col: expected %0d, actual %0d", want.col, center_col);
      fail_count++;
    end
    if (frame_last !== want.last) begin
      $error("frame_last: expected %0d, actual %0d", want.last, frame_last);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++)
        for (int j = 0; j < 5; j++)
          win[i][j] = '0;
      col_pos = 0;
      row_pos = 0;
      mode_5x5 = 1'b0;
      width_reg = 11'd512;
      height_reg = 11'd512;
      expected_medians.delete();
    end else begin
      if (median_valid && median_ready) begin
        check_median();
        result_count++;
      end
      // A pixel taken at the same edge as a register write still sees the old value.
      if (pixel_valid && pixel_ready) take_pixel(pixel_value);
      if (cfg_write) begin
        case (cfg_index)
          REG_WINDOW_MODE: begin
            mode_5x5 = cfg_data[0];
          end
          REG_FRAME_WIDTH: begin
            width_reg = cfg_data;
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/window_median_filter_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
// Top of the median filter testbench. It drives pixel frames and register writes,
// applies back pressure on the median channel and gives the verdict; all
// prediction and median comparison happen in the checker module beside the block.
module window_median_filter_test;
  import wmf_pkg::*;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;
  logic                pixel_valid;
  logic                pixel_ready;
  pixel_t              pixel_value;
  logic                median_valid;
  logic                median_ready;
  pixel_t              median_value;
  logic [ROW_BITS-1:0] center_row;
  logic [COL_BITS-1:0] center_col;
  logic                frame_last;
  int                  fail_count;
  int                  pending;
  int                  result_count;

  // Idle percentages of the sender and the receiver, changed between phases.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned pixels_sent;
  int unsigned frames_sent;

  window_median_filter DUT (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .pixel_valid, .pixel_ready, .pixel_value,
    .median_valid, .median_ready, .median_value,
    .center_row, .center_col, .frame_last
  );

  window_median_filter_checker checker_inst (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .pixel_valid, .pixel_ready, .pixel_value,
    .median_valid, .median_ready, .median_value,
    .center_row, .center_col, .frame_last,
    .fail_count, .pending, .result_count
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver stalls at random; it is re-decided on every clock edge.
  always @(posedge clk) begin
    median_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offers one pixel after a random number of idle cycles, and holds it until
  // pixel_ready is seen high just after an edge. Valid stays high into the next
  // pixel when no idle cycle follows.
  task automatic send_pixel(pixel_t pix);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_value <= pix;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    pixels_sent++;
  endtask

  // Drops valid, lets the pipeline drain, since border pixels leave no result
  // to wait for, and then waits until every predicted median has arrived.
  task automatic wait_drained();
    pixel_valid <= 1'b0;
    repeat (20) @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_frame(logic mode, logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h);
    wait_drained();
    write_reg(REG_WINDOW_MODE, {10'd0, mode});
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    cfg_write <= 1'b0;
  endtask

  // Kinds of pixel content: uniform noise, salt and pepper, and flat fields.
  typedef enum int {FILL_RANDOM, FILL_SALT, FILL_FLAT} fill_kind_t;

  task automatic send_frame(int unsigned count, fill_kind_t kind);
    pixel_t base;
    pixel_t pix;
    base = pixel_t'($urandom);
    for (int unsigned i = 0; i < count; i++) begin
      case (kind)
        FILL_SALT: begin
          pix = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00) : base;
        end
        FILL_FLAT: begin
          pix = base;
        end
        default: begin
          pix = pixel_t'($urandom);
        end
      endcase
      send_pixel(pix);
    end
    frames_sent++;
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_WINDOW_MODE;
    cfg_data = '0;
    pixel_valid = 1'b0;
    pixel_value = '0;
    send_idle_pct = 15;
    recv_idle_pct = 50;
    pixels_sent = 0;
    frames_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: a 5x5 frame in 3x3 mode with the extremes of the pixel
    // range, so every interior median sees 0 and 255 mixed together.
    set_frame(1'b0, 11'd5, 11'd5);
    for (int i = 0; i < 25; i++) send_pixel((i % 2) ? 8'hFF : 8'h00);

    // A 5x5 frame in 5x5 mode gives a single centre, which is also the last.
    set_frame(1'b1, 11'd5, 11'd5);
    send_frame(25, FILL_RANDOM);

    // Sizes below the minimum saturate to five; heights above the maximum
    // saturate to MAX_HEIGHT, so only the first rows are sent there.
    set_frame(1'b0, 11'd0, 11'd2);
    send_frame(25, FILL_SALT);
    set_frame(1'b1, 11'd5, 11'h7FF);
    send_frame(40, FILL_FLAT);
    set_frame(1'b0, 11'd5, 11'd1024);
    send_frame(40, FILL_RANDOM);

    // Shrink the frame mid-row: the position now lies past the new width, so
    // the next pixels give no result and the counter wraps.
    set_frame(1'b0, 11'd12, 11'd6);
    send_frame(20, FILL_RANDOM);
    set_frame(1'b0, 11'd6, 11'd6);
    send_frame(36, FILL_RANDOM);
    // Switch mode in the middle of a frame.
    set_frame(1'b1, 11'd6, 11'd6);
    send_frame(20, FILL_SALT);

    // Random frames in three idling phases; the sender pauses for a full drain
    // between frames.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 15 : ((phase == 1) ? 50 : 0);
      recv_idle_pct = (phase == 0) ? 50 : ((phase == 1) ? 15 : 0);
      for (int f = 0; f < 2; f++) begin
        logic [CFG_BITS-1:0] w, h;
        w = CFG_BITS'($urandom_range(5, 12));
        h = CFG_BITS'($urandom_range(5, 9));
        set_frame(logic'($urandom_range(1)), w, h);
        send_frame(w * h, fill_kind_t'($urandom_range(2)));
      end
    end

    wait_drained();
    $display("Covered %0d pixels in %0d frames, both window sizes and clamped sizes;",
             pixels_sent, frames_sent);
    $display("%0d medians were checked under three stall patterns.", result_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire
